/* design/assert_macros.svh */
// Assertion macros included by the run-list lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/drvl_pkg.sv */
// Shared types, constants and helpers for the run-list lookup.
package drvl_pkg;

	// Fixed widths of the port fields.
	localparam int VcnPortW = 48;
	localparam int WordW    = 64;
	localparam int ByteW    = 8;

	// Largest byte count a header nibble may give.
	localparam logic [3:0] MaxFieldBytes = 4'd8;

	// Decoder phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_TERM      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	// Sign-extends an offset that was read as n little-endian bytes.
	// Eight bytes (and zero bytes, where the value is zero) pass unchanged.
	function automatic logic [WordW-1:0] sext_delta(input logic [WordW-1:0] v,
			input logic [3:0] n);
		logic [WordW-1:0] r;
		r = v;
		case (n)
			4'd1: r = {{56{v[7]}},  v[7:0]};
			4'd2: r = {{48{v[15]}}, v[15:0]};
			4'd3: r = {{40{v[23]}}, v[23:0]};
			4'd4: r = {{32{v[31]}}, v[31:0]};
			4'd5: r = {{24{v[39]}}, v[39:0]};
			4'd6: r = {{16{v[47]}}, v[47:0]};
			4'd7: r = {{8{v[55]}},  v[55:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

/* design/data_run_vcn_to_lcn_lookup.sv */
// Run-list lookup: takes the bytes of a run list one beat at a time and
// answers where a query VCN lives on disk. A beat with first set starts a
// lookup and carries the query, low and high VCN; the block then decodes
// each run header, length and signed LCN delta, and gives at most one result
// beat per lookup (found, terminator, out of range, or malformed header). One
// run-list byte is taken every cycle while no result beat is held; the figure
// is set by the decode stage, whose state (accumulators, running LCN, base
// VCN) is updated from the input register. A result passes from the input
// register through the result stage to the output register. Intake stops
// only while a result beat is held by out_stall. Beats without first after
// a lookup has finished are dropped.
module data_run_vcn_to_lcn_lookup
	import drvl_pkg::*;
#(
	parameter int VCN_BITS = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	// Run-list byte channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                first,
	input  logic [VcnPortW-1:0] query_vcn,
	input  logic [VcnPortW-1:0] low_vcn,
	input  logic [VcnPortW-1:0] high_vcn,
	input  logic [ByteW-1:0]    run_byte,
	// Result channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [WordW-1:0]    lcn,
	output logic [WordW-1:0]    run_remaining,
	output logic                sparse
);

	// The whole pipeline moves unless a result beat is held downstream.
	logic out_valid_q;
	logic advance;
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// Input register.
	logic                valid_s1;
	logic                first_s1;
	logic [VCN_BITS-1:0] query_s1;
	logic [VCN_BITS-1:0] low_s1;
	logic [VCN_BITS-1:0] high_s1;
	logic [ByteW-1:0]    byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			first_s1 <= first;
			query_s1 <= query_vcn[VCN_BITS-1:0];
			low_s1   <= low_vcn[VCN_BITS-1:0];
			high_s1  <= high_vcn[VCN_BITS-1:0];
			byte_s1  <= run_byte;
		end
	end

	// Decoder state.
	phase_t              phase_q;
	logic [4:0]          bytes_left_q;
	logic [3:0]          length_bytes_q;
	logic [3:0]          offset_bytes_q;
	logic [WordW-1:0]    run_len_q;
	logic [WordW-1:0]    offset_q;
	logic [WordW-1:0]    running_lcn_q;
	logic [WordW-1:0]    base_vcn_q;
	logic [VCN_BITS-1:0] target_q;

	phase_t              phase_d;
	logic [4:0]          bytes_left_d;
	logic [3:0]          length_bytes_d;
	logic [3:0]          offset_bytes_d;
	logic [WordW-1:0]    run_len_d;
	logic [WordW-1:0]    offset_d;
	logic [WordW-1:0]    running_lcn_d;
	logic [WordW-1:0]    base_vcn_d;
	logic [VCN_BITS-1:0] target_d;

	// Result of the decode stage.
	logic             res_d;
	status_t          res_status_d;
	logic [WordW-1:0] res_lcn_d;
	logic [WordW-1:0] res_into_d;
	logic [WordW-1:0] res_len_d;
	logic             res_sparse_d;

	// Working values of the decode stage.
	logic             do_header;
	logic             do_body;
	logic [3:0]       nib_len;
	logic [3:0]       nib_off;
	logic [4:0]       consumed;
	logic [4:0]       off_pos;
	logic [WordW-1:0] byte_wide;
	logic [WordW-1:0] lcn_next;
	logic [WordW-1:0] target_wide;
	logic [WordW-1:0] into;
	logic             hit;

	assign nib_len     = byte_s1[3:0];
	assign nib_off     = byte_s1[7:4];
	assign byte_wide   = {{(WordW-ByteW){1'b0}}, byte_s1};
	assign target_wide = {{(WordW-VCN_BITS){1'b0}}, target_q};
	assign consumed    = (5'(length_bytes_q) + 5'(offset_bytes_q)) - bytes_left_q;
	assign off_pos     = consumed - 5'(length_bytes_q);

	// Header, body and end-of-run decoding for the registered byte.
	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		length_bytes_d = length_bytes_q;
		offset_bytes_d = offset_bytes_q;
		run_len_d      = run_len_q;
		offset_d       = offset_q;
		running_lcn_d  = running_lcn_q;
		base_vcn_d     = base_vcn_q;
		target_d       = target_q;
		res_d          = 1'b0;
		res_status_d   = ST_FOUND;
		res_lcn_d      = '0;
		res_into_d     = '0;
		res_len_d      = '0;
		res_sparse_d   = 1'b0;
		do_header      = 1'b0;
		do_body        = 1'b0;
		lcn_next       = '0;
		into           = '0;
		hit            = 1'b0;

		if (first_s1) begin
			// A new lookup restarts from any phase.
			target_d       = query_s1;
			running_lcn_d  = '0;
			base_vcn_d     = {{(WordW-VCN_BITS){1'b0}}, low_s1};
			bytes_left_d   = '0;
			length_bytes_d = '0;
			offset_bytes_d = '0;
			run_len_d      = '0;
			offset_d       = '0;
			if (query_s1 < low_s1 || query_s1 > high_s1) begin
				phase_d      = PH_DONE;
				res_d        = 1'b1;
				res_status_d = ST_RANGE;
			end else begin
				do_header = 1'b1;
			end
		end else if (phase_q == PH_HEADER) begin
			do_header = 1'b1;
		end else if (phase_q == PH_BODY) begin
			do_body = 1'b1;
		end

		if (do_header) begin
			if (byte_s1 == '0) begin
				phase_d      = PH_DONE;
				res_d        = 1'b1;
				res_status_d = ST_TERM;
			end else if (nib_len > MaxFieldBytes || nib_off > MaxFieldBytes) begin
				phase_d      = PH_DONE;
				res_d        = 1'b1;
				res_status_d = ST_MALFORMED;
			end else begin
				length_bytes_d = nib_len;
				offset_bytes_d = nib_off;
				bytes_left_d   = 5'(nib_len) + 5'(nib_off);
				run_len_d      = '0;
				offset_d       = '0;
				phase_d        = PH_BODY;
			end
		end

		if (do_body) begin
			// Length bytes come first, then offset bytes, both little-endian.
			if (consumed < 5'(length_bytes_q)) begin
				run_len_d = run_len_q | (byte_wide << {consumed[2:0], 3'b000});
			end else begin
				offset_d = offset_q | (byte_wide << {off_pos[2:0], 3'b000});
			end
			bytes_left_d = bytes_left_q - 5'd1;

			// Last byte of the run: move the LCN and test for a match.
			if (bytes_left_q == 5'd1) begin
				lcn_next      = running_lcn_q + sext_delta(offset_d, offset_bytes_q);
				running_lcn_d = lcn_next;
				into          = target_wide - base_vcn_q;
				hit           = (target_wide >= base_vcn_q) && (into < run_len_d);
				if (hit) begin
					phase_d      = PH_DONE;
					res_d        = 1'b1;
					res_status_d = ST_FOUND;
					res_lcn_d    = lcn_next;
					res_into_d   = into;
					res_len_d    = run_len_d;
					res_sparse_d = (offset_bytes_q == '0);
				end else begin
					base_vcn_d = base_vcn_q + run_len_d;
					phase_d    = PH_HEADER;
				end
			end
		end
	end

	// Decoder state update, one byte per cycle while the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bytes_left_q   <= '0;
			length_bytes_q <= '0;
			offset_bytes_q <= '0;
			run_len_q      <= '0;
			offset_q       <= '0;
			running_lcn_q  <= '0;
			base_vcn_q     <= '0;
			target_q       <= '0;
		end else if (advance && valid_s1) begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			length_bytes_q <= length_bytes_d;
			offset_bytes_q <= offset_bytes_d;
			run_len_q      <= run_len_d;
			offset_q       <= offset_d;
			running_lcn_q  <= running_lcn_d;
			base_vcn_q     <= base_vcn_d;
			target_q       <= target_d;
		end
	end

	// Result stage: holds the raw figures of a finished lookup.
	logic             res_valid_s2;
	status_t          status_s2;
	logic [WordW-1:0] lcn_s2;
	logic [WordW-1:0] into_s2;
	logic [WordW-1:0] len_s2;
	logic             sparse_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1 && res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= res_status_d;
			lcn_s2    <= res_lcn_d;
			into_s2   <= res_into_d;
			len_s2    <= res_len_d;
			sparse_s2 <= res_sparse_d;
		end
	end

	// Output register: final LCN and remaining clusters.
	status_t          status_q;
	logic [WordW-1:0] lcn_q;
	logic [WordW-1:0] remaining_q;
	logic             sparse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= status_s2;
			lcn_q       <= sparse_s2 ? '0 : (lcn_s2 + into_s2);
			remaining_q <= len_s2 - into_s2;
			sparse_q    <= sparse_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign lcn           = lcn_q;
	assign run_remaining = remaining_q;
	assign sparse        = sparse_q;

	`include "assert_macros.svh"

	// A lookup that did not find its run reports all fields as zero.
	`ASSERT_SAME(a_miss_zero, out_valid && status_q != ST_FOUND, lcn == '0 && run_remaining == '0 && !sparse, "miss result carries nonzero fields")
	// A sparse run is a found run and reports LCN zero.
	`ASSERT_SAME(a_sparse_lcn, out_valid && sparse, status_q == ST_FOUND && lcn == '0, "sparse result with LCN or wrong status")
	// A found VCN lies inside its run, so at least one cluster remains.
	`ASSERT_SAME(a_found_rem, out_valid && status_q == ST_FOUND, run_remaining != '0, "found result with no clusters remaining")
	// While a run body is read, bytes remain to be read.
	`ASSERT_SAME(a_body_left, phase_q == PH_BODY, bytes_left_q != '0, "body phase with no bytes left")
	// A result held in the result stage reaches the output register next cycle when the pipeline advances.
	`ASSERT_NEXT(a_res_flow, advance && res_valid_s2, out_valid_q, "result beat lost between stages")

endmodule

/* tb/sv/run_lookup_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the run-list lookup, decodes every accepted
// run-list beat on its own copy of the decoder state and compares each
// result beat with the oldest answer still due.
module run_lookup_checker
	import drvl_pkg::*;
#(
	parameter int VCN_BITS = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                first,
	input  logic [VcnPortW-1:0] query_vcn,
	input  logic [VcnPortW-1:0] low_vcn,
	input  logic [VcnPortW-1:0] high_vcn,
	input  logic [ByteW-1:0]    run_byte,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [1:0]          status,
	input  logic [WordW-1:0]    lcn,
	input  logic [WordW-1:0]    run_remaining,
	input  logic                sparse,
	output int                  fails,
	output int                  pending
);

	// One answer of a lookup, as the result channel should carry it.
	typedef struct packed {
		status_t          st;
		logic [WordW-1:0] lcn;
		logic [WordW-1:0] remaining;
		logic             sp;
	} answer_t;

	localparam logic [WordW-1:0] VcnMask = (64'd1 << VCN_BITS) - 64'd1;

	// Decoder state as the block should hold it.
	phase_t           dec_phase;
	int unsigned      bytes_left;
	int unsigned      len_bytes;
	int unsigned      off_bytes;
	logic [WordW-1:0] len_acc;
	logic [WordW-1:0] off_acc;
	logic [WordW-1:0] run_lcn;
	logic [WordW-1:0] base_vcn;
	logic [WordW-1:0] target_vcn;

	answer_t answers_due[$];
	int      mismatch_cnt;

	// Queues the answer for one terminal status with all data fields zero.
	task automatic close_lookup(input status_t st);
		answer_t a;
		a.st        = st;
		a.lcn       = '0;
		a.remaining = '0;
		a.sp        = 1'b0;
		dec_phase   = PH_DONE;
		answers_due.push_back(a);
	endtask

	// Advances the decoder by one accepted run-list beat.
	task automatic decode_beat(input logic f, input logic [VcnPortW-1:0] q,
			input logic [VcnPortW-1:0] lo, input logic [VcnPortW-1:0] hi,
			input logic [ByteW-1:0] b);
		logic [WordW-1:0] qm;
		logic [WordW-1:0] lom;
		logic [WordW-1:0] him;
		logic [WordW-1:0] delta;
		logic [WordW-1:0] into;
		int unsigned      consumed;
		int unsigned      bits;
		logic             is_sparse;
		logic             take_hdr;
		answer_t          a;
		take_hdr = 1'b0;
		if (f) begin
			// A first beat restarts the lookup whatever the phase.
			qm         = WordW'(q) & VcnMask;
			lom        = WordW'(lo) & VcnMask;
			him        = WordW'(hi) & VcnMask;
			target_vcn = qm;
			run_lcn    = '0;
			base_vcn   = lom;
			bytes_left = 0;
			len_bytes  = 0;
			off_bytes  = 0;
			len_acc    = '0;
			off_acc    = '0;
			if (qm < lom || qm > him) begin
				close_lookup(ST_RANGE);
			end else begin
				take_hdr = 1'b1;
			end
		end else if (dec_phase == PH_HEADER) begin
			take_hdr = 1'b1;
		end else if (dec_phase == PH_BODY) begin
			// Length bytes come first, then the offset bytes, both little-endian.
			consumed = len_bytes + off_bytes - bytes_left;
			if (consumed < len_bytes) begin
				len_acc |= WordW'(b) << (8 * (consumed % 8));
			end else begin
				off_acc |= WordW'(b) << (8 * ((consumed - len_bytes) % 8));
			end
			bytes_left--;
			if (bytes_left == 0) begin
				// The run is complete: apply the signed delta and test for a match.
				is_sparse = (off_bytes == 0);
				delta     = is_sparse ? '0 : off_acc;
				if (!is_sparse && off_bytes < 8) begin
					bits = off_bytes * 8;
					if (delta[bits-1]) begin
						delta |= ~((64'd1 << bits) - 64'd1);
					end
				end
				run_lcn += delta;
				if (target_vcn >= base_vcn && (target_vcn - base_vcn) < len_acc) begin
					into        = target_vcn - base_vcn;
					a.st        = ST_FOUND;
					a.lcn       = is_sparse ? '0 : run_lcn + into;
					a.remaining = len_acc - into;
					a.sp        = is_sparse;
					dec_phase   = PH_DONE;
					answers_due.push_back(a);
				end else begin
					base_vcn += len_acc;
					dec_phase = PH_HEADER;
				end
			end
		end
		// Header byte: terminator, malformed nibble, or the sizes of the next run.
		if (take_hdr) begin
			if (b == '0) begin
				close_lookup(ST_TERM);
			end else if (b[3:0] > MaxFieldBytes || b[7:4] > MaxFieldBytes) begin
				close_lookup(ST_MALFORMED);
			end else begin
				len_bytes  = 32'(b[3:0]);
				off_bytes  = 32'(b[7:4]);
				bytes_left = len_bytes + off_bytes;
				len_acc    = '0;
				off_acc    = '0;
				dec_phase  = PH_BODY;
			end
		end
	endtask

	// Prediction on the input channel, comparison on the result channel.
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		if (!arst_n) begin
			dec_phase    = PH_IDLE;
			bytes_left   = 0;
			len_bytes    = 0;
			off_bytes    = 0;
			len_acc      = '0;
			off_acc      = '0;
			run_lcn      = '0;
			base_vcn     = '0;
			target_vcn   = '0;
			mismatch_cnt = 0;
			answers_due.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_beat(first, query_vcn, low_vcn, high_vcn, run_byte);
			end
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("unexpected result beat: status %0d lcn %h remaining %h sparse %b",
							status, lcn, run_remaining, sparse);
					end
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st || lcn !== want.lcn ||
							run_remaining !== want.remaining || sparse !== want.sp) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("result mismatch: expected status %0d lcn %h remaining %h sparse %b,",
								want.st, want.lcn, want.remaining, want.sp,
								" got status %0d lcn %h remaining %h sparse %b",
								status, lcn, run_remaining, sparse);
						end
					end
				end
			end
			fails   <= mismatch_cnt;
			pending <= answers_due.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Drives run lists into the lookup block and gives the verdict; the checker
// beside the block does all prediction and comparison.
module tb
	import drvl_pkg::*;
();

	localparam int RandomBeats = 1950;
	localparam int CycleLimit  = 400000;
	localparam int HoldCycles  = 300;
	localparam logic [VcnPortW-1:0] VcnMax = '1;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                first;
	logic [VcnPortW-1:0] query_vcn;
	logic [VcnPortW-1:0] low_vcn;
	logic [VcnPortW-1:0] high_vcn;
	logic [ByteW-1:0]    run_byte;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [WordW-1:0]    lcn;
	logic [WordW-1:0]    run_remaining;
	logic                sparse;

	int fails;
	int pending;

	// Idle rates of both sides and the long receiver hold-off requests.
	int tx_idle_pct = 24;
	int rx_idle_pct = 56;
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_left   = 0;
	int beats_sent  = 0;

	data_run_vcn_to_lcn_lookup #(
		.VCN_BITS(48)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first        (first),
		.query_vcn    (query_vcn),
		.low_vcn      (low_vcn),
		.high_vcn     (high_vcn),
		.run_byte     (run_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.lcn          (lcn),
		.run_remaining(run_remaining),
		.sparse       (sparse)
	);

	run_lookup_checker #(
		.VCN_BITS(48)
	) answer_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first        (first),
		.query_vcn    (query_vcn),
		.low_vcn      (low_vcn),
		.high_vcn     (high_vcn),
		.run_byte     (run_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.lcn          (lcn),
		.run_remaining(run_remaining),
		.sparse       (sparse),
		.fails        (fails),
		.pending      (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("[data_run_vcn_to_lcn_lookup] ERROR");
		$finish;
	end

	// Result receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HoldCycles;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	function automatic logic [VcnPortW-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[VcnPortW-1:0];
	endfunction

	// Offers one beat, with random idle cycles ahead of it, until it is taken.
	task automatic send_beat(input logic f, input logic [VcnPortW-1:0] q,
			input logic [VcnPortW-1:0] lo, input logic [VcnPortW-1:0] hi,
			input logic [ByteW-1:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		first     <= f;
		query_vcn <= q;
		low_vcn   <= lo;
		high_vcn  <= hi;
		run_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Sends one lookup: the query rides on the first byte, later beats carry junk.
	task automatic send_lookup(input logic [VcnPortW-1:0] q, input logic [VcnPortW-1:0] lo,
			input logic [VcnPortW-1:0] hi, input logic [ByteW-1:0] bytes[$]);
		foreach (bytes[i]) begin
			if (i == 0) begin
				send_beat(1'b1, q, lo, hi, bytes[i]);
			end else begin
				send_beat(1'b0, rand48(), rand48(), rand48(), bytes[i]);
			end
		end
		beats_sent += bytes.size();
	endtask

	// Stops offering beats until every answer due has come back.
	task automatic wait_for_answers();
		int guard;
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Builds a mostly well-formed run list with random content and a random query.
	task automatic send_random_lookup();
		logic [ByteW-1:0]    seq[$];
		logic [WordW-1:0]    total;
		logic [WordW-1:0]    run_len;
		logic [WordW-1:0]    pick;
		logic [VcnPortW-1:0] lo;
		logic [VcnPortW-1:0] q;
		logic [VcnPortW-1:0] hi;
		logic [ByteW-1:0]    bv;
		int                  nruns;
		int                  n1;
		int                  n2;
		int                  sel;
		int                  cut;
		sel = $urandom_range(0, 9);
		if (sel < 4) lo = '0;
		else if (sel < 7) lo = VcnPortW'($urandom_range(0, 5000));
		else lo = rand48();
		total = '0;
		nruns = $urandom_range(0, 4);
		repeat (nruns) begin
			// Mostly short fields, now and then empty or the full eight bytes.
			sel = $urandom_range(0, 9);
			if (sel < 7) n1 = $urandom_range(1, 2);
			else if (sel == 7) n1 = 0;
			else if (sel == 8) n1 = $urandom_range(3, 7);
			else n1 = 8;
			sel = $urandom_range(0, 9);
			if (sel < 2) n2 = 0;
			else if (sel < 7) n2 = $urandom_range(1, 3);
			else if (sel == 7) n2 = $urandom_range(4, 7);
			else n2 = 8;
			if (n1 == 0 && n2 == 0) n1 = 1;
			seq.push_back({4'(n2), 4'(n1)});
			run_len = '0;
			for (int k = 0; k < n1; k++) begin
				bv = 8'($urandom);
				seq.push_back(bv);
				run_len |= WordW'(bv) << (8 * k);
			end
			total += run_len;
			repeat (n2) seq.push_back(8'($urandom));
		end
		// The query mostly lands inside the runs, sometimes just past or outside them.
		sel  = $urandom_range(0, 19);
		pick = {$urandom, $urandom};
		if (sel < 14) q = lo + VcnPortW'((total == '0) ? '0 : pick % total);
		else if (sel < 16) q = lo + VcnPortW'(total);
		else if (sel < 18) q = lo - 48'd1;
		else q = rand48();
		sel = $urandom_range(0, 9);
		if (sel < 7) hi = VcnMax;
		else if (sel < 9) hi = q + VcnPortW'($urandom_range(0, 3));
		else hi = q - 48'd1;
		// Ending: terminator, malformed header, cut short, or left open.
		sel = $urandom_range(0, 19);
		if (sel < 15) begin
			seq.push_back(8'h00);
		end else if (sel < 17) begin
			bv = 8'($urandom);
			if ($urandom_range(0, 1) == 1) bv[3:0] = 4'($urandom_range(9, 15));
			else bv[7:4] = 4'($urandom_range(9, 15));
			seq.push_back(bv);
		end else if (sel < 19 && seq.size() > 1) begin
			cut = $urandom_range(1, seq.size() - 1);
			seq = seq[0:cut-1];
		end
		if (seq.size() == 0) seq.push_back(8'h00);
		send_lookup(q, lo, hi, seq);
		// Occasional stray beats without a first flag.
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				send_beat(1'b0, rand48(), rand48(), rand48(), 8'($urandom));
			end
		end
	endtask

	// Reset, directed lookups, then three idle regimes of random lookups.
	initial begin : stimulus
		logic paused;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		first     <= 1'b0;
		query_vcn <= '0;
		low_vcn   <= '0;
		high_vcn  <= '0;
		run_byte  <= '0;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Query below and above the attribute's range.
		send_lookup(48'd5, 48'd10, 48'd100, '{8'h11});
		send_lookup(VcnMax, '0, VcnMax - 48'd1, '{8'h00});
		// Terminator as the very first header.
		send_lookup('0, '0, VcnMax, '{8'h00});
		// Malformed length nibble, malformed offset nibble, and both.
		send_lookup(48'd7, '0, VcnMax, '{8'h09});
		send_lookup(48'd7, '0, VcnMax, '{8'h91});
		send_lookup(48'd7, '0, VcnMax, '{8'hFF});
		// Sparse run.
		send_lookup(48'd3, '0, VcnMax, '{8'h01, 8'h20});
		// Second run with a negative delta.
		send_lookup(48'd6, '0, VcnMax, '{8'h11, 8'h04, 8'h40, 8'h11, 8'h04, 8'hF0});
		// Zero-length run ahead of the matching one.
		send_lookup(48'd100, 48'd100, 48'd200, '{8'h10, 8'h05, 8'h01, 8'h02});
		// Base at the top of the VCN space.
		send_lookup(VcnMax, VcnMax, VcnMax, '{8'h01, 8'h01});
		// A stray byte once the lookup is done.
		send_beat(1'b0, '0, '0, '0, 8'hA5);
		// Lookup left in the middle of a run, then restarted.
		send_lookup('0, '0, VcnMax, '{8'h31, 8'h00});
		// Delta that wraps the running LCN below zero.
		send_lookup(48'd1, '0, 48'd1, '{8'h11, 8'hFF, 8'h80});

		beats_sent = 0;
		while (beats_sent < RandomBeats) begin
			if (beats_sent >= 650 && tx_idle_pct == 24) begin
				tx_idle_pct = 56;
				rx_idle_pct = 24;
			end
			if (beats_sent >= 1300 && rx_idle_pct != 0) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// Long receiver hold-off while beats keep coming.
			if (beats_sent >= 300 && holds_asked == 0) holds_asked = 1;
			if (beats_sent >= 1000 && !paused) begin
				paused = 1'b1;
				wait_for_answers();
			end
			send_random_lookup();
		end

		wait_for_answers();
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("[data_run_vcn_to_lcn_lookup] OK");
		end else begin
			$display("[data_run_vcn_to_lcn_lookup] ERROR");
		end
		$finish;
	end

endmodule
